// ===== sv/stc_pkg.sv =====
// ----------------------------------------------------------------------------
// stc_pkg: shared constants and types for the sine/cosine series block
// Fixed-point formats, digit-serial multiplier sizing and cell control.
// ----------------------------------------------------------------------------
package stc_pkg;
  localparam int TERMS      = 20;
  localparam int FRAC_BITS  = 30;
  localparam int RECIP_BITS = FRAC_BITS + 16;
  localparam int ANGLE_FRAC = 28;
  localparam int OUT_FRAC   = 30;

  localparam int MAG_W  = FRAC_BITS + 16;
  localparam int DIG_W  = 16;
  localparam int NDIG   = (MAG_W + DIG_W - 1) / DIG_W;
  localparam int PROD_W = MAG_W + DIG_W * NDIG;
  localparam int SUM_W  = MAG_W + 2;
  localparam int KW     = $clog2(TERMS);
  localparam int CW     = (NDIG > 1) ? $clog2(NDIG) : 1;

  typedef logic [DIG_W-1:0] digit_t;
  typedef logic [MAG_W-1:0] mag_t;

  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctrl_t;
endpackage

// ===== sv/stc_if.sv =====
// ----------------------------------------------------------------------------
// stc_in_if / stc_out_if: valid/ready channels of the sine/cosine block
// Request carries op and angle, response carries the value.
// ----------------------------------------------------------------------------
interface stc_in_if;
  logic               valid;
  logic               ready;
  logic               op;
  logic signed [31:0] angle;
  modport source (output valid, output op, output angle, input ready);
  modport sink   (input valid, input op, input angle, output ready);
endinterface

interface stc_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value;
  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

// ===== sv/stc_cell.sv =====
// ----------------------------------------------------------------------------
// stc_cell: one digit cell of the multiplier operand shift line
// Load a digit in parallel, or take the neighbor's digit each cycle that shift is set.
// ----------------------------------------------------------------------------
module stc_cell import stc_pkg::*; (
  input  logic       clk,
  input  cell_ctrl_t ctrl,
  input  digit_t     load_digit,
  input  digit_t     shift_in,
  output digit_t     digit_q
);
  digit_t digit_r;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      digit_r <= load_digit;
    end else if (ctrl.shift) begin
      digit_r <= shift_in;
    end
  end

  assign digit_q = digit_r;
endmodule

// ===== sv/sine_cosine_taylor.sv =====
// ----------------------------------------------------------------------------
// sine_cosine_taylor: sine or cosine by a truncated Maclaurin series
// Signed Q4.28 angle in, signed Q2.30 result out, saturated to +-1.
// ----------------------------------------------------------------------------
//
//  channel  | dir | payload                      | transaction
//  ---------+-----+------------------------------+---------------------------
//  in_ch    | in  | op (0 sin, 1 cos), angle     | valid && ready
//  out_ch   | out | value (Q2.30)                | valid && ready
//
// Sequence: each multiply runs through the digits in S_MUL, then rounds in
//   S_RND, on a single MAG_W x 16 multiplier fed from the row of digit cells.
//   An item squares the angle, then takes two multiplies per further term;
//   the next item is taken once the result leaves.
// Reset: rst_n synchronous, active low; clears the sequencer only.
// Stalls: the result holds on out_ch until taken; in_ch is not ready meanwhile.
//
module sine_cosine_taylor import stc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  stc_in_if.sink    in_ch,
  stc_out_if.source out_ch
);
  typedef enum logic [2:0] {S_IDLE, S_MUL, S_RND, S_FIN, S_OUT} state_t;
  typedef enum logic [1:0] {P_SQ, P_T1, P_T2} phase_t;

  // angle rescale Q.28 -> Q.FRAC_BITS, output rescale Q.FRAC_BITS -> Q.30
  localparam int ASH_L = (FRAC_BITS >= ANGLE_FRAC) ? FRAC_BITS - ANGLE_FRAC : 0;
  localparam int ASH_R = (FRAC_BITS < ANGLE_FRAC) ? ANGLE_FRAC - FRAC_BITS : 0;
  localparam int OSH_L = (FRAC_BITS < OUT_FRAC) ? OUT_FRAC - FRAC_BITS : 0;
  localparam int OSH_R = (FRAC_BITS > OUT_FRAC) ? FRAC_BITS - OUT_FRAC : 0;
  localparam int OW    = SUM_W + OSH_L;

  state_t state_r;
  phase_t phase_r;
  logic              op_r;
  logic              t_neg_r;
  logic              x_neg_r;
  mag_t              x_mag_r;
  mag_t              x2_r;
  mag_t              a_r;
  logic [PROD_W-1:0] acc_r;
  logic [CW-1:0]     cnt_r;
  logic [KW-1:0]     k_r;
  logic signed [SUM_W-1:0] sum_r;
  logic signed [31:0] value_r;

  // reciprocal tables, rounded to Q0.RECIP_BITS
  mag_t recip_sin [TERMS];
  mag_t recip_cos [TERMS];
  for (genvar k = 0; k < TERMS; k++) begin : g_recip
    localparam longint unsigned DS = (k == 0) ? 1 : (2 * k) * (2 * k + 1);
    localparam longint unsigned DC = (k == 0) ? 1 : (2 * k - 1) * (2 * k);
    localparam longint unsigned RS = ((64'd1 << RECIP_BITS) + DS / 2) / DS;
    localparam longint unsigned RC = ((64'd1 << RECIP_BITS) + DC / 2) / DC;
    assign recip_sin[k] = MAG_W'(RS);
    assign recip_cos[k] = MAG_W'(RC);
  end

  // input angle magnitude in Q.FRAC_BITS
  logic        in_acc;
  logic        a_neg;
  logic [31:0] a_abs;
  mag_t        x_in;
  assign in_acc = in_ch.valid && in_ch.ready;
  assign a_neg  = in_ch.angle[31];
  assign a_abs  = a_neg ? 32'(-in_ch.angle) : 32'(in_ch.angle);
  assign x_in   = ((MAG_W'(a_abs) + (MAG_W'(1) << ASH_R >> 1)) >> ASH_R) << ASH_L;

  // digit cell row: top cell feeds the multiplier, lower digits move up
  cell_ctrl_t               cell_ctrl;
  mag_t                     b_mag;
  logic [DIG_W*NDIG-1:0]    b_pad;
  digit_t                   digit [NDIG];
  assign b_pad = (DIG_W*NDIG)'(b_mag);

  for (genvar i = 0; i < NDIG; i++) begin : g_cell
    digit_t sh_in;
    if (i == 0) begin : g_first
      assign sh_in = '0;
    end else begin : g_next
      assign sh_in = digit[i-1];
    end
    stc_cell u_cell (
      .clk        (clk),
      .ctrl       (cell_ctrl),
      .load_digit (b_pad[i*DIG_W +: DIG_W]),
      .shift_in   (sh_in),
      .digit_q    (digit[i])
    );
  end

  // multiply-accumulate, most significant digit first
  logic [MAG_W+DIG_W-1:0] prod;
  logic [PROD_W-1:0]      acc_nxt;
  assign prod    = a_r * digit[NDIG-1];
  assign acc_nxt = {acc_r[PROD_W-DIG_W-1:0], DIG_W'(0)} + PROD_W'(prod);

  // round to nearest, ties away, for both shift amounts
  logic [PROD_W-1:0] rf_sum, rr_sum;
  mag_t              rnd_f, rnd_r;
  assign rf_sum = acc_r + (PROD_W'(1) << (FRAC_BITS - 1));
  assign rr_sum = acc_r + (PROD_W'(1) << (RECIP_BITS - 1));
  assign rnd_f  = rf_sum[FRAC_BITS +: MAG_W];
  assign rnd_r  = rr_sum[RECIP_BITS +: MAG_W];

  mag_t recip_sel;
  assign recip_sel = op_r ? recip_cos[k_r] : recip_sin[k_r];

  logic signed [SUM_W-1:0] x_signed, t_signed;
  assign x_signed = x_neg_r ? -$signed({2'b00, x_mag_r}) : $signed({2'b00, x_mag_r});
  assign t_signed = t_neg_r ? -$signed({2'b00, rnd_r}) : $signed({2'b00, rnd_r});

  // final rescale and saturation
  logic [SUM_W-1:0] s_abs;
  logic [OW-1:0]    s_scaled;
  logic [OW-1:0]    s_cap;
  logic signed [31:0] val_c;
  always_comb begin
    s_abs    = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);
    s_scaled = ((OW'(s_abs) + (OW'(1) << OSH_R >> 1)) >> OSH_R) << OSH_L;
    s_cap    = (s_scaled > (OW'(1) << OUT_FRAC)) ? (OW'(1) << OUT_FRAC) : s_scaled;
    val_c    = sum_r[SUM_W-1] ? -$signed(s_cap[31:0]) : $signed(s_cap[31:0]);
  end

  // load the digit row at each multiply start
  always_comb begin
    cell_ctrl.load  = 1'b0;
    cell_ctrl.shift = (state_r == S_MUL);
    b_mag           = '0;
    unique case (state_r)
      S_IDLE: begin
        cell_ctrl.load = in_acc;
        b_mag          = x_in;
      end
      S_RND: begin
        unique case (phase_r)
          P_SQ: begin
            cell_ctrl.load = 1'b1;
            b_mag          = rnd_f;
          end
          P_T1: begin
            cell_ctrl.load = 1'b1;
            b_mag          = recip_sel;
          end
          P_T2: begin
            cell_ctrl.load = (k_r != KW'(TERMS - 1));
            b_mag          = x2_r;
          end
          default: begin
            cell_ctrl.load = 1'b0;
          end
        endcase
      end
      default: begin
        cell_ctrl.load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      phase_r <= P_SQ;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            op_r    <= in_ch.op;
            x_neg_r <= a_neg;
            x_mag_r <= x_in;
            t_neg_r <= in_ch.op ? 1'b0 : a_neg;
            a_r     <= x_in;
            acc_r   <= '0;
            cnt_r   <= '0;
            phase_r <= P_SQ;
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          acc_r <= acc_nxt;
          cnt_r <= cnt_r + CW'(1);
          if (cnt_r == CW'(NDIG - 1)) begin
            state_r <= S_RND;
          end
        end
        S_RND: begin
          acc_r <= '0;
          cnt_r <= '0;
          unique case (phase_r)
            P_SQ: begin
              x2_r    <= rnd_f;
              a_r     <= op_r ? (MAG_W'(1) << FRAC_BITS) : x_mag_r;
              sum_r   <= op_r ? (SUM_W'(1) << FRAC_BITS) : x_signed;
              k_r     <= KW'(1);
              phase_r <= P_T1;
              state_r <= S_MUL;
            end
            P_T1: begin
              // times x squared, then flip the sign
              a_r     <= rnd_f;
              t_neg_r <= ~t_neg_r;
              phase_r <= P_T2;
              state_r <= S_MUL;
            end
            P_T2: begin
              sum_r <= sum_r + t_signed;
              a_r   <= rnd_r;
              if (k_r == KW'(TERMS - 1)) begin
                state_r <= S_FIN;
              end else begin
                k_r     <= k_r + KW'(1);
                phase_r <= P_T1;
                state_r <= S_MUL;
              end
            end
            default: begin
              state_r <= S_IDLE;
            end
          endcase
        end
        S_FIN: begin
          value_r <= val_c;
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_ch.ready) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ch.ready  = (state_r == S_IDLE);
  assign out_ch.valid = (state_r == S_OUT);
  assign out_ch.value = value_r;

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !out_ch.valid)
    else $error("input ready while a result is pending");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ch.ready)
    else $error("second transaction taken while busy");

  a_saturated: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.value <= 32'sd1073741824 &&
                      out_ch.value >= -32'sd1073741824))
    else $error("result outside plus or minus one");

  a_term_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RND && phase_r == P_T2) |-> (k_r != '0))
    else $error("series index lost");
endmodule
